[sv/assert_macros.svh]
// Assertion macros shared by the checker files of the shadow return stack.
// No dependencies; the checker that needs them takes this file by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define SRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shadow return stack check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define SRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shadow return stack check failed");

// As above, but also checked while reset is asserted.
`define SRS_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("shadow return stack check failed");

`endif

[sv/srs_pkg.sv]
// Package for the shadow return stack: transaction types and status codes.
// No dependencies.
`default_nettype none

package srs_pkg;

    // Command codes.
    localparam logic CMD_CALL = 1'b0;
    localparam logic CMD_RET  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_PUSHED   = 3'd0;
    localparam logic [2:0] ST_MATCH    = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [31:0] ret_addr;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] expected_addr;
        logic [6:0]  depth_after;
    } t_out;

endpackage

`default_nettype wire

[sv/srs_stack.sv]
// Stack core: count, top-of-stack and next-below registers, and the entry memory.
// Depends on srs_pkg.
`default_nettype none

module srs_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire srs_pkg::t_in  i_item,
    output srs_pkg::t_out      o_result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // The top entry lives in r_top and the one beneath it in r_below; the
    // memory holds every entry except the top, so a pop never waits on a read.
    logic [31:0]   mem [STACK_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [31:0]   r_top;
    logic [31:0]   r_below;

    logic          is_ret;
    logic          full;
    logic          empty;
    logic          match;
    logic          do_push;
    logic          do_pop;
    logic [2:0]    status;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign is_ret  = (i_item.cmd == srs_pkg::CMD_RET);
    assign full    = (r_count == CW'(STACK_DEPTH));
    assign empty   = (r_count == '0);
    assign match   = (i_item.ret_addr == r_top);
    assign do_push = i_valid && !is_ret && !full;
    assign do_pop  = i_valid && is_ret && !empty && match;
    assign wr_addr = AW'(r_count - CW'(1));
    assign rd_addr = AW'(r_count - CW'(3));

    always_comb begin
        if (!is_ret) begin
            status = full ? srs_pkg::ST_OVERFLOW : srs_pkg::ST_PUSHED;
        end else if (empty) begin
            status = srs_pkg::ST_EMPTY;
        end else if (match) begin
            status = srs_pkg::ST_MATCH;
        end else begin
            status = srs_pkg::ST_MISMATCH;
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CW'(1);
        end else if (do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    assign o_result.status        = status;
    assign o_result.expected_addr = empty ? 32'd0 : r_top;
    assign o_result.depth_after   = 7'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top <= i_item.ret_addr;
        end else if (do_pop) begin
            r_top <= r_below;
        end
    end

    // A push spills the old top into the memory; a pop refills r_below
    // from the entry two beneath the old top.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            if (!empty) begin
                mem[wr_addr] <= r_top;
            end
            r_below <= r_top;
        end else if (do_pop) begin
            r_below <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/shadow_return_stack_checker.sv]
// Top level of the shadow return stack: input register, stack core, result register.
// Depends on srs_pkg and srs_stack.
// A transaction is accepted into the input register, the stack core works on it from
// there and its result is loaded into the output register. Throughput: one transaction
// per cycle while the output is not stalled. Reset (synchronous, active low) empties
// the stack and both pipeline stages; memory is kept.
`default_nettype none

module shadow_return_stack_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire srs_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output srs_pkg::t_out      o_out_data
);

    // Input stage: holds one accepted transaction until the stack core
    // has processed it.
    logic          r_in_valid;
    srs_pkg::t_in  r_in;

    // Output stage: the result waits here while the consumer stalls.
    logic          r_out_valid;
    srs_pkg::t_out r_out;

    logic          advance;
    srs_pkg::t_out result;

    // The pipeline moves whenever the output register is free or being
    // emptied this cycle. The input stage stalls only when it is full and
    // cannot move on, so a new transaction enters in every cycle otherwise.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // The stack state only changes when the transaction in the input stage
    // actually moves into the output register, so a stall never repeats it.
    srs_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid && advance),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[sv/srs_checker.sv]
// Port-level checks for the shadow return stack, bound to the top level.
// Depends on srs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srs_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_out_valid,
    input wire logic          i_out_stall,
    input wire srs_pkg::t_out i_out_data
);

    // A stalled result stays offered.
    `SRS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)

    // A stalled result keeps its payload.
    `SRS_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_data))

    // A return on an empty stack leaves it empty and reports no expected address.
    `SRS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_out_valid && (i_out_data.status == srs_pkg::ST_EMPTY), (i_out_data.expected_addr == 32'd0) && (i_out_data.depth_after == 7'd0))

    // No result is offered in the cycle after reset.
    `SRS_ASSERT_NXT_ALL(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind shadow_return_stack_checker srs_checker u_srs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for shadow_return_stack_checker: random call and return traffic
// with random idling on both channels, checked against an in-bench model of the stack.
// Depends on srs_pkg and the RTL of the block; needs no files or arguments.

module testbench;

    localparam int STACK_DEPTH   = 64;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 200;
    // The result is registered after the input register; this wait covers that with margin.
    localparam int SETTLE_CYCLES = 8;

    // Kinds of random sequence. Nested traffic is the bulk of the run; the others push
    // the stack to its limits or feed it rubbish.
    typedef enum int {SEQ_NEST, SEQ_FILL, SEQ_DRAIN, SEQ_NOISE} t_seq_kind;

    // Keeps its own copy of the stack, works out the result of every accepted
    // transaction and compares the results of the block with those, oldest first.
    class t_return_stack_scoreboard;
        logic [31:0]           frames [STACK_DEPTH];
        int unsigned           count;
        srs_pkg::t_out         pending_results [$];
        int unsigned           errors;
        int unsigned           reported;
        int unsigned           checked;
        int unsigned           deepest;
        int unsigned           n_pushed, n_match, n_mismatch, n_empty, n_overflow;

        function int unsigned depth();
            return count;
        endfunction

        function logic [31:0] top_addr();
            return (count > 0) ? frames[count - 1] : 32'h0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Updates the stack for one accepted transaction and queues the result it must give.
        function void note_request(srs_pkg::t_in req);
            srs_pkg::t_out res;
            res.expected_addr = top_addr();
            if (req.cmd == srs_pkg::CMD_CALL) begin
                if (count < STACK_DEPTH) begin
                    frames[count] = req.ret_addr;
                    count++;
                    res.status = srs_pkg::ST_PUSHED;
                    n_pushed++;
                end else begin
                    res.status = srs_pkg::ST_OVERFLOW;
                    n_overflow++;
                end
            end else if (count == 0) begin
                res.status = srs_pkg::ST_EMPTY;
                n_empty++;
            end else if (req.ret_addr == frames[count - 1]) begin
                count--;
                res.status = srs_pkg::ST_MATCH;
                n_match++;
            end else begin
                res.status = srs_pkg::ST_MISMATCH;
                n_mismatch++;
            end
            if (count > deepest)
                deepest = count;
            res.depth_after = count[6:0];
            pending_results.push_back(res);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (reported < REPORT_LIMIT) begin
                reported++;
                $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                         $time, checked, what, want, got);
            end
        endfunction

        function void check_result(srs_pkg::t_out got);
            srs_pkg::t_out want;
            if (pending_results.size() == 0) begin
                report("unexpected result, status", 32'h0, {29'h0, got.status});
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report("status", {29'h0, want.status}, {29'h0, got.status});
            if (got.expected_addr !== want.expected_addr)
                report("expected_addr", want.expected_addr, got.expected_addr);
            if (got.depth_after !== want.depth_after)
                report("depth_after", {25'h0, want.depth_after}, {25'h0, got.depth_after});
            checked++;
        endfunction

        function void summary();
            $display("Run covered %0d transactions, deepest stack %0d entries:",
                     checked, deepest);
            $display("  %0d pushes, %0d matched returns, %0d mismatches,",
                     n_pushed, n_match, n_mismatch);
            $display("  %0d empty-stack returns, %0d overflow drops",
                     n_empty, n_overflow);
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    srs_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    srs_pkg::t_out  o_out_data;

    t_return_stack_scoreboard shadow_sb;

    int unsigned cycles;
    int unsigned sent;
    bit          quiet_input;   // when set the sender runs without gaps
    bit          draining;      // when set the receiver stops stalling

    shadow_return_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog. Should the block hang, the run is stopped here with a failure.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycles, shadow_sb.pending());
        $display("shadow_return_stack_checker test failed");
        $finish;
    end

    // Length of the idle gap before a transaction: mostly none, sometimes a
    // short gap and now and then a long pause.
    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_input || r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // An address to push. Besides plain random values it offers the extremes,
    // a copy of the current top (so equal neighbours appear) and a near miss of it.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return shadow_sb.top_addr();
            3: return shadow_sb.top_addr() ^ (32'h1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    // Drives one transaction after a random gap and holds it until the block takes it.
    // Valid is left high afterwards so that back-to-back transactions really are
    // back to back; the next call or idle_input decides what happens to it.
    task automatic send(input logic cmd, input logic [31:0] addr);
        srs_pkg::t_in req;
        int           gap;
        req.cmd      = cmd;
        req.ret_addr = addr;
        gap = gap_len();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        // Accepted at this edge: the model is brought up to date at once, so the
        // next address is chosen from the state the block will hold.
        shadow_sb.note_request(req);
        sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // A return that must match: it presents the address on top of the stack.
    task automatic send_matching_return();
        send(srs_pkg::CMD_RET, shadow_sb.top_addr());
    endtask

    // A return that differs from the top in exactly one bit.
    task automatic send_near_miss();
        send(srs_pkg::CMD_RET, shadow_sb.top_addr() ^ (32'h1 << $urandom_range(0, 31)));
    endtask

    // One step of well-formed nested traffic with the odd faulty return mixed in.
    task automatic nest_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (shadow_sb.depth() == 0) begin
            if (r < 80)
                send(srs_pkg::CMD_CALL, pick_addr());
            else
                send(srs_pkg::CMD_RET, $urandom());
        end else if (r < 48 || (shadow_sb.depth() < 3 && r < 65)) begin
            send(srs_pkg::CMD_CALL, pick_addr());
        end else if (r < 87) begin
            send_matching_return();
        end else if (r < 96) begin
            send_near_miss();
        end else begin
            send(srs_pkg::CMD_RET, $urandom());
        end
    endtask

    // Receiver: alternates runs of taking results with runs of stalls. Most runs
    // are short; a few are long, and some free runs are long enough to let the
    // pipeline stream at full rate.
    initial begin : result_receiver
        bit          stalling;
        int unsigned run_left;
        int unsigned r;
        stalling    = 1'b0;
        run_left    = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                stalling = ~stalling;
                r = $urandom_range(0, 99);
                if (stalling)
                    run_left = (r < 75) ? $urandom_range(1, 3)
                             : (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 50);
                else
                    run_left = (r < 70) ? $urandom_range(1, 4)
                             : (r < 95) ? $urandom_range(5, 30) : $urandom_range(40, 120);
            end
            run_left--;
            i_out_stall <= (stalling && !draining);
        end
    end

    // Results are taken at the rising edge. Stall only changes at the falling
    // edge, so the sampled values are those the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            shadow_sb.check_result(o_out_data);
    end

    initial begin : stimulus
        t_seq_kind   kind;
        int unsigned chunk;
        int unsigned r;
        shadow_sb   = new;
        sent        = 0;
        quiet_input = 1'b0;
        draining    = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: returns on an empty stack, the extreme addresses
        // pushed and returned, matches and near misses at both ends of the range.
        send(srs_pkg::CMD_RET,  32'h0000_0000);
        send(srs_pkg::CMD_RET,  32'hffff_ffff);
        send(srs_pkg::CMD_CALL, 32'hffff_ffff);
        send(srs_pkg::CMD_CALL, 32'h0000_0000);
        send(srs_pkg::CMD_RET,  32'hffff_ffff);   // top is zero: mismatch, stack kept
        send(srs_pkg::CMD_RET,  32'h0000_0000);   // match, pops back to all ones
        send(srs_pkg::CMD_RET,  32'hffff_fffe);   // mismatch in the lowest bit
        send(srs_pkg::CMD_RET,  32'h7fff_ffff);   // mismatch in the highest bit
        send(srs_pkg::CMD_RET,  32'hffff_ffff);   // match, stack empty again
        send(srs_pkg::CMD_RET,  32'hffff_ffff);   // empty again
        send(srs_pkg::CMD_CALL, 32'h8000_0000);
        send(srs_pkg::CMD_CALL, 32'h0000_0001);
        send(srs_pkg::CMD_CALL, 32'h0000_0001);   // the same address twice in a row
        send(srs_pkg::CMD_RET,  32'h0000_0001);
        send(srs_pkg::CMD_RET,  32'h0000_0000);   // mismatch against the remaining copy
        send(srs_pkg::CMD_RET,  32'h0000_0001);
        send(srs_pkg::CMD_RET,  32'h0000_0000);   // mismatch against the bottom entry
        send(srs_pkg::CMD_RET,  32'h8000_0000);
        send(srs_pkg::CMD_CALL, 32'h5555_5555);
        send(srs_pkg::CMD_CALL, 32'haaaa_aaaa);
        send(srs_pkg::CMD_RET,  32'h5555_5555);
        send(srs_pkg::CMD_RET,  32'haaaa_aaaa);
        send(srs_pkg::CMD_RET,  32'h5555_5555);

        // Random part, built from sequences. The first one fills the stack to the
        // brim and runs into overflow, so that the full and dropped cases are
        // reached early in every run whatever the seed.
        chunk = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet_input = ($urandom_range(0, 5) == 0);
            // Now and then the sender waits until every result is back, so the
            // block also sees transactions arriving into a drained pipeline.
            if (chunk % 9 == 4) begin
                idle_input();
                while (shadow_sb.pending() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (chunk == 0)
                kind = SEQ_FILL;
            else if (r < 55)
                kind = SEQ_NEST;
            else if (r < 68)
                kind = SEQ_FILL;
            else if (r < 82)
                kind = SEQ_DRAIN;
            else
                kind = SEQ_NOISE;

            case (kind)
                SEQ_NEST: begin
                    repeat ($urandom_range(20, 60)) nest_step();
                end
                SEQ_FILL: begin
                    while (shadow_sb.depth() < STACK_DEPTH)
                        send(srs_pkg::CMD_CALL, pick_addr());
                    // Calls that find the stack full, then some traffic at the top.
                    repeat ($urandom_range(1, 3)) send(srs_pkg::CMD_CALL, pick_addr());
                    if ($urandom_range(0, 1) == 1)
                        send_near_miss();
                    send_matching_return();
                    send(srs_pkg::CMD_CALL, pick_addr());
                end
                SEQ_DRAIN: begin
                    // Unwinds the whole stack, with occasional faulty returns
                    // that must leave it untouched.
                    while (shadow_sb.depth() > 0) begin
                        if ($urandom_range(0, 9) == 0)
                            send_near_miss();
                        send_matching_return();
                    end
                    repeat ($urandom_range(1, 2)) send(srs_pkg::CMD_RET, pick_addr());
                end
                default: begin
                    repeat ($urandom_range(5, 25))
                        send(1'($urandom_range(0, 1)), $urandom());
                end
            endcase
            chunk++;
        end
        quiet_input = 1'b0;
        idle_input();

        // Let every outstanding result come out, then watch a little longer for
        // anything that should not appear.
        draining = 1'b1;
        while (shadow_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        shadow_sb.summary();
        if (shadow_sb.errors == 0) begin
            $display("shadow_return_stack_checker test passed");
        end else begin
            $display("%0d mismatches found", shadow_sb.errors);
            $display("shadow_return_stack_checker test failed");
        end
        $finish;
    end

endmodule
